// File: rtl/core/nvcb_pkg.sv
// ----------------------------------------------------------------------------
// nvcb_pkg: shared types and constants for the NVMe I/O command builder
// Controller states, controller/datapath handshake structs, opcodes, field
// widths and stream bit layout.
// ----------------------------------------------------------------------------
package nvcb_pkg;

  // opcodes
  localparam logic [1:0] OP_NONE  = 2'h0;
  localparam logic [1:0] OP_WRITE = 2'h1;
  localparam logic [1:0] OP_READ  = 2'h2;

  // result kinds (m_axis_tuser)
  localparam logic KIND_LIST = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // list entries emitted per command at most
  localparam int unsigned LIST_CAP   = 16;
  localparam int unsigned LIDX_W     = 4;
  localparam int unsigned SECTOR_LOG = 9;   // 512-byte sectors
  localparam int unsigned LEN_W      = 18;  // byte counts up to 255 * 512 + page

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 328;
  localparam int unsigned OUT_USED_W = 321;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_LIST,
    ST_CMD
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic calc;      // page math, command id
    logic step;      // list entry taken
    logic done;      // command taken
    logic emit_cmd;  // output shows the command
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic need_list;
    logic list_done;
  } stat_t;

endpackage

// File: rtl/core/nvcb_ctrl.sv
// ----------------------------------------------------------------------------
// nvcb_ctrl: request sequencer
// Steps one request through capture, page math, list entries and command.
// ----------------------------------------------------------------------------
module nvcb_ctrl
  import nvcb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  output logic  m_valid_o,
  input  logic  m_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = stat_i.need_list ? ST_LIST : ST_CMD;
      end
      ST_LIST: begin
        if (m_ready_i && stat_i.list_done) state_d = ST_CMD;
      end
      ST_CMD: begin
        if (m_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    ctrl_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o   = 1'b1;
        ctrl_o.load = s_valid_i;
      end
      ST_CALC: begin
        ctrl_o.calc = 1'b1;
      end
      ST_LIST: begin
        m_valid_o   = 1'b1;
        ctrl_o.step = m_ready_i;
      end
      ST_CMD: begin
        m_valid_o       = 1'b1;
        ctrl_o.emit_cmd = 1'b1;
        ctrl_o.done     = m_ready_i;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/nvcb_dp.sv
// ----------------------------------------------------------------------------
// nvcb_dp: command datapath
// Request registers, PRP page math, list walker, command id, queue tail and
// the list base register.
// ----------------------------------------------------------------------------
module nvcb_dp
  import nvcb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PAGE_BYTES  = 4096,
  parameter int unsigned MAX_SECTORS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o,
  input  logic                  is_write_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  base_we_i,
  input  logic [63:0]           base_wdata_i,
  output logic [63:0]           base_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int unsigned TAIL_W    = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [LEN_W-1:0]  PageLen  = LEN_W'(PAGE_BYTES);
  localparam logic [10:0]       MaxSec   = 11'(MAX_SECTORS);
  localparam logic [TAIL_W-1:0] TailLast = TAIL_W'(QUEUE_DEPTH - 1);

  logic        wr_q;
  logic [31:0] ns_q;
  logic [63:0] lba_q;
  logic [7:0]  cnt_q, cnt_sat;
  logic [63:0] addr_q;
  logic [63:0] prp2_q, prp2_d;
  logic [63:0] ptr_q;
  logic [LIDX_W-1:0] idx_q, last_idx_q, last_idx_d;
  logic [15:0] cid_q;
  logic [TAIL_W-1:0] tail_q;
  logic [63:0] base_q;

  logic [LEN_W-1:0] bytes, head_len, left, ent_sum;
  logic [LEN_W-PAGE_BITS-1:0] entries;
  logic need_list;

  // request fields from stream word
  logic [31:0] in_ns;
  logic [63:0] in_lba, in_addr;
  logic [7:0]  in_cnt;
  assign in_ns   = in_data_i[31:0];
  assign in_lba  = in_data_i[95:32];
  assign in_cnt  = in_data_i[103:96];
  assign in_addr = in_data_i[167:104];

  // zero -> one, clamp to max
  always_comb begin
    cnt_sat = in_cnt;
    if (in_cnt == 8'd0) cnt_sat = 8'd1;
    if ({3'b000, in_cnt} > MaxSec) cnt_sat = MaxSec[7:0];
  end

  // page math on captured request
  always_comb begin
    bytes     = LEN_W'({cnt_q, {SECTOR_LOG{1'b0}}});
    head_len  = PageLen - LEN_W'(addr_q[PAGE_BITS-1:0]);
    left      = bytes - head_len;
    ent_sum   = left + (PageLen - LEN_W'(1));
    entries   = ent_sum[LEN_W-1:PAGE_BITS];
    need_list = (bytes > head_len) && (left > PageLen);
    if (LEN_W'(entries) > LEN_W'(LIST_CAP)) begin
      last_idx_d = LIDX_W'(LIST_CAP - 1);
    end else begin
      last_idx_d = LIDX_W'(entries - (LEN_W-PAGE_BITS)'(1));
    end
    if (need_list) begin
      prp2_d = base_q;
    end else if (bytes > head_len) begin
      prp2_d = addr_q + 64'(head_len);
    end else begin
      prp2_d = '0;
    end
  end

  assign stat_o.need_list = need_list;
  assign stat_o.list_done = (idx_q == last_idx_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      wr_q   <= is_write_i;
      ns_q   <= in_ns;
      lba_q  <= in_lba;
      cnt_q  <= cnt_sat;
      addr_q <= in_addr;
    end
    if (ctrl_i.calc) begin
      prp2_q     <= prp2_d;
      ptr_q      <= addr_q + 64'(head_len);
      idx_q      <= '0;
      last_idx_q <= last_idx_d;
    end else if (ctrl_i.step) begin
      ptr_q <= ptr_q + 64'(PageLen);
      idx_q <= idx_q + LIDX_W'(1);
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cid_q  <= '0;
      tail_q <= '0;
      base_q <= '0;
    end else begin
      if (ctrl_i.calc) cid_q <= cid_q + 16'd1;
      if (ctrl_i.done) tail_q <= (tail_q == TailLast) ? '0 : tail_q + TAIL_W'(1);
      if (base_we_i) base_q <= base_wdata_i;
    end
  end

  assign base_o = base_q;

  // result word; fields not used by the kind read as zero
  always_comb begin
    out_data_o = '0;
    if (ctrl_i.emit_cmd) begin
      out_data_o[1:0]     = wr_q ? OP_WRITE : OP_READ;
      out_data_o[17:2]    = cid_q;
      out_data_o[49:18]   = ns_q;
      out_data_o[113:50]  = addr_q;
      out_data_o[177:114] = prp2_q;
      out_data_o[241:178] = lba_q;
      out_data_o[248:242] = 7'(cnt_q - 8'd1);
      out_data_o[252:249] = 4'(tail_q);
    end else begin
      out_data_o[256:253] = idx_q;
      out_data_o[320:257] = ptr_q;
    end
  end

endmodule

// File: rtl/core/nvme_io_command_builder.sv
// ----------------------------------------------------------------------------
// nvme_io_command_builder: NVMe I/O submission entry builder with PRP setup
// Turns one block read/write request into optional PRP list entries followed
// by one submission command item.
// ----------------------------------------------------------------------------
// Sequence: a request is taken in idle, its page math is registered in the calc state,
//   then the PRP list entries (0..16) and the command item follow at one result item
//   per cycle while m_axis_tready is high; a new request is taken only after the command.
// Reset (rst_ni low, async): sequencer idle, command id 0, queue tail 0,
//   prp_list_base 0.
module nvme_io_command_builder
  import nvcb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,    // 2..4096
  parameter int unsigned PAGE_BYTES  = 4096,  // power of two, 4096..65536
  parameter int unsigned MAX_SECTORS = 128    // 1..1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] namespace_id, [95:32] start_lba, [103:96] sector_count,
  // [167:104] buffer_address
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,   // [0] is_write
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] opcode, [17:2] command_id, [49:18] namespace_out, [113:50] prp1,
  // [177:114] prp2, [241:178] lba_out, [248:242] blocks_minus_one,
  // [252:249] queue_slot, [256:253] list_index, [320:257] list_entry, rest 0
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,   // [0] kind
  output logic                  m_axis_tlast,   // last
  // register port: prp_list_base at 0x0
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  ctrl_t       ctrl;
  stat_t       stat;
  logic        base_we;
  logic [63:0] base;

  // Register decode: index = paddr[3]; only index 0 exists.
  assign pready  = 1'b1;
  assign base_we = psel && penable && pwrite && !paddr[3];
  assign prdata  = paddr[3] ? 64'd0 : base;

  nvcb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  nvcb_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAGE_BYTES  (PAGE_BYTES),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .is_write_i   (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .base_we_i    (base_we),
    .base_wdata_i (pwdata),
    .base_o       (base),
    .out_data_o   (m_axis_tdata)
  );

  // command item closes the run; list entries come before it
  assign m_axis_tuser = ctrl.emit_cmd ? KIND_CMD : KIND_LIST;
  assign m_axis_tlast = ctrl.emit_cmd;

endmodule

// File: rtl/core/nvcb_chk.sv
// ----------------------------------------------------------------------------
// nvcb_chk: port-level checker for the command builder
// Watches result sequencing and request acceptance on the stream ports.
// ----------------------------------------------------------------------------
module nvcb_chk
  import nvcb_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // only the command item ends a run
  a_last_is_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
    else $error("tlast not on command item");

  // no new request while results are pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken during result run");

  // a list entry is always followed by another result
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("run ended without command item");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind nvme_io_command_builder nvcb_chk u_nvcb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level check of nvme_io_command_builder
// Sends block read/write requests over the request stream, programs the PRP
// list base over the register port, and compares every PRP list entry and
// submission command item field by field against a predictor of the builder.
// ----------------------------------------------------------------------------
module testbench;
  import nvcb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // build parameters, kept at their defaults
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PAGE_SIZE   = 4096;
  localparam int unsigned MAX_SECTORS = 128;

  localparam logic [63:0] PAGE_BYTES64 = 64'(PAGE_SIZE);
  localparam logic [63:0] SECTOR_BYTES = 64'd512;

  // register map: prp_list_base is register 0, anything above is unmapped
  localparam logic [3:0] ADDR_PRP_LIST_BASE = 4'h0;
  localparam logic [3:0] ADDR_UNMAPPED      = 4'h8;

  localparam int unsigned STALL_LIMIT  = 5000;  // cycles with no handshake
  localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 20;    // tail after the last result

  // request item, tdata layout from the highest bit down
  typedef struct packed {
    logic [63:0] buffer_address;
    logic [7:0]  sector_count;
    logic [63:0] start_lba;
    logic [31:0] namespace_id;
  } req_t;

  // result tdata layout from the highest bit down, pad bits must stay 0
  typedef struct packed {
    logic [6:0]  pad;
    logic [63:0] list_entry;
    logic [3:0]  list_index;
    logic [3:0]  queue_slot;
    logic [6:0]  blocks_minus_one;
    logic [63:0] lba_out;
    logic [63:0] prp2;
    logic [63:0] prp1;
    logic [31:0] namespace_out;
    logic [15:0] command_id;
    logic [1:0]  opcode;
  } sqe_word_t;

  typedef struct packed {
    logic      kind;
    logic      last;
    sqe_word_t word;
  } result_t;

  // one request plus, where easy to read off, the command fields it must give
  typedef struct {
    logic        is_write;
    req_t        req;
    bit          typed;
    logic [15:0] cid;
    logic [3:0]  slot;
    logic [63:0] prp2;
    logic [6:0]  nlb;
  } request_row_t;

  logic clk_i;
  logic rst_ni;

  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] namespace_id, [95:32] start_lba,
                                         // [103:96] sector_count, [167:104] buffer_address
  logic                  s_axis_tuser;   // [0] is_write
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [1:0] opcode .. [320:257] list_entry, see sqe_word_t
  logic                  m_axis_tuser;   // [0] kind
  logic                  m_axis_tlast;   // last
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [3:0]            paddr;
  logic [63:0]           pwdata;
  logic [63:0]           prdata;
  logic                  pready;

  nvme_io_command_builder #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAGE_BYTES  (PAGE_SIZE),
    .MAX_SECTORS (MAX_SECTORS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state: mirrors the builder's command id, queue tail and register
  // --------------------------------------------------------------------------
  logic [15:0] next_cmd_id;
  int unsigned sq_tail;
  logic [63:0] list_base;

  result_t      expected_items[$];   // list entries and commands still to come
  request_row_t request_rows[$];     // directed stimulus table

  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned list_items_seen;
  int unsigned commands_seen;
  int unsigned idle_cycles;

  // idling controls shared by the sender, receiver and main sequence
  bit          no_idle;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned rx_stall_left;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mismatch report: one line per failure, each one counted.
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("[%0t] mismatch %s: expected %h got %h", $time, name, want, got);
    end
  endtask

  // Mostly short gaps, sometimes medium, rarely long.
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 10) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: list entries go straight to the expectation queue, the command
  // is handed back so directed rows can pin its fields.
  // --------------------------------------------------------------------------
  function automatic void predict_submission(input logic wr, input req_t r,
                                             output result_t cmd);
    int unsigned sectors;
    int unsigned i;
    logic [63:0] bytes;
    logic [63:0] head_len;
    logic [63:0] left;
    logic [63:0] entries;
    logic [63:0] page_addr;
    logic [63:0] second_ptr;
    result_t     ent;

    // zero counts as one sector, oversized counts saturate
    sectors = 32'(r.sector_count);
    if (sectors == 0) sectors = 1;
    if (sectors > MAX_SECTORS) sectors = MAX_SECTORS;
    bytes      = 64'(sectors) * SECTOR_BYTES;
    // low address bits are not masked, they shrink the first page
    head_len   = PAGE_BYTES64 - (r.buffer_address % PAGE_BYTES64);
    second_ptr = '0;

    if (bytes > head_len) begin
      if (bytes <= head_len + PAGE_BYTES64) begin
        second_ptr = r.buffer_address + head_len;
      end else begin
        left      = bytes - head_len;
        page_addr = r.buffer_address + head_len;  // wraps mod 2^64
        entries   = (left + PAGE_BYTES64 - 1) / PAGE_BYTES64;
        if (entries > LIST_CAP) entries = 64'(LIST_CAP);
        for (i = 0; i < entries; i++) begin
          ent                 = '0;
          ent.kind            = KIND_LIST;
          ent.word.list_index = i[LIDX_W-1:0];
          ent.word.list_entry = page_addr;
          expected_items.push_back(ent);
          page_addr += PAGE_BYTES64;
        end
        second_ptr = list_base;
      end
    end

    next_cmd_id++;  // pre-increment, wraps at 16 bits
    cmd                       = '0;
    cmd.kind                  = KIND_CMD;
    cmd.last                  = 1'b1;
    cmd.word.opcode           = wr ? OP_WRITE : OP_READ;
    cmd.word.command_id       = next_cmd_id;
    cmd.word.namespace_out    = r.namespace_id;
    cmd.word.prp1             = r.buffer_address;
    cmd.word.prp2             = second_ptr;
    cmd.word.lba_out          = r.start_lba;
    cmd.word.blocks_minus_one = 7'(sectors - 1);
    cmd.word.queue_slot       = sq_tail[3:0];
    sq_tail                   = (sq_tail + 1) % QUEUE_DEPTH;
  endfunction

  // --------------------------------------------------------------------------
  // Request sender: drive at the falling edge, wait for the handshake, then
  // predict in the same time step as the acceptance.
  // --------------------------------------------------------------------------
  task automatic issue(input request_row_t row);
    int unsigned gap;
    result_t     cmd;
    gap = 0;
    if (!no_idle && $urandom_range(0, 2) != 0) gap = pick_idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.req;
    s_axis_tuser  <= row.is_write;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    predict_submission(row.is_write, row.req, cmd);
    if (row.typed) begin
      cmd.word.command_id       = row.cid;
      cmd.word.queue_slot       = row.slot;
      cmd.word.prp2             = row.prp2;
      cmd.word.blocks_minus_one = row.nlb;
    end
    expected_items.push_back(cmd);
  endtask

  task automatic add_row(input logic wr, input logic [31:0] ns, input logic [63:0] lba,
                         input logic [7:0] cnt, input logic [63:0] addr, input bit typed,
                         input logic [15:0] cid, input logic [3:0] slot,
                         input logic [63:0] prp2, input logic [6:0] nlb);
    request_row_t row;
    row.is_write = wr;
    row.req      = '{buffer_address: addr, sector_count: cnt, start_lba: lba,
                     namespace_id: ns};
    row.typed    = typed;
    row.cid      = cid;
    row.slot     = slot;
    row.prp2     = prp2;
    row.nlb      = nlb;
    request_rows.push_back(row);
  endtask

  // Random request: mostly legal counts and aligned buffers, some oddities.
  function automatic request_row_t random_request(input bit short_only);
    request_row_t row;
    int unsigned  sel;
    row              = '{default: '0};
    row.is_write     = 1'($urandom_range(0, 1));
    row.req.namespace_id = $urandom;
    row.req.start_lba    = {$urandom, $urandom};
    sel = $urandom_range(0, 19);
    if (short_only)      row.req.sector_count = 8'($urandom_range(1, 8));
    else if (sel < 13)   row.req.sector_count = 8'($urandom_range(1, MAX_SECTORS));
    else if (sel < 16)   row.req.sector_count = 8'($urandom_range(1, 17));
    else if (sel == 16)  row.req.sector_count = 8'd0;
    else                 row.req.sector_count = 8'($urandom_range(MAX_SECTORS + 1, 255));
    row.req.buffer_address = {$urandom, $urandom};
    // dword aligned unless the request is deliberately off
    if ($urandom_range(0, 9) != 0) row.req.buffer_address[1:0] = 2'b00;
    // push the start close to the page end to stretch the list
    if ($urandom_range(0, 3) == 0)
      row.req.buffer_address[11:2] = 10'h3FF - 10'($urandom_range(0, 15));
    // near the top of the address space, so page addresses wrap
    if ($urandom_range(0, 15) == 0) row.req.buffer_address[63:20] = '1;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Register port: setup cycle, access cycle, write lands when pready is high
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [3:0] addr,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr && addr == ADDR_PRP_LIST_BASE) list_base = wdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_list_base(input logic [63:0] value);
    logic [63:0] rd;
    apb_access(1'b1, ADDR_PRP_LIST_BASE, value, rd);
    apb_access(1'b0, ADDR_PRP_LIST_BASE, '0, rd);
    check_field("prp_list_base readback", value, rd);
  endtask

  // Stop offering, let every expected item come back, then a short tail so
  // the sequencer is back in idle before the register changes.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) issue(random_request(1'b0));
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off on request so the
  // builder backs up into its request side.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    logic ready_next;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (!no_idle && rx_stall_left == 0 && $urandom_range(0, 5) == 0)
          rx_stall_left = pick_idle_len();
        if (rx_stall_left != 0) begin
          rx_stall_left--;
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
        end
      end
      m_axis_tready <= ready_next;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    result_t   want;
    sqe_word_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (m_axis_tuser == KIND_LIST) list_items_seen++;
      else commands_seen++;
      if (expected_items.size() == 0) begin
        check_field("unexpected item, tdata low bits", '0, m_axis_tdata[63:0]);
        check_field("unexpected item", 64'd0, 64'd1);
      end else begin
        want = expected_items.pop_front();
        check_field("kind",             64'(want.kind),                  64'(m_axis_tuser));
        check_field("last",             64'(want.last),                  64'(m_axis_tlast));
        check_field("opcode",           64'(want.word.opcode),           64'(got.opcode));
        check_field("command_id",       64'(want.word.command_id),       64'(got.command_id));
        check_field("namespace_out",    64'(want.word.namespace_out),    64'(got.namespace_out));
        check_field("prp1",             want.word.prp1,                  got.prp1);
        check_field("prp2",             want.word.prp2,                  got.prp2);
        check_field("lba_out",          want.word.lba_out,               got.lba_out);
        check_field("blocks_minus_one", 64'(want.word.blocks_minus_one), 64'(got.blocks_minus_one));
        check_field("queue_slot",       64'(want.word.queue_slot),       64'(got.queue_slot));
        check_field("list_index",       64'(want.word.list_index),       64'(got.list_index));
        check_field("list_entry",       want.word.list_entry,            got.list_entry);
        check_field("tdata pad",        64'(want.word.pad),              64'(got.pad));
      end
    end
  end

  // Watchdog: any handshake on either stream or the register port resets it.
  always @(posedge clk_i) begin : stall_watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    logic [63:0] scratch;
    int unsigned k;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    next_cmd_id   = '0;
    sq_tail       = 0;
    list_base     = '0;
    mismatches    = 0;
    requests_sent = 0;
    list_items_seen = 0;
    commands_seen = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    rx_stall_left = 0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // unmapped register write must leave the list base at its reset value
    apb_access(1'b1, ADDR_UNMAPPED, '1, scratch);

    // Directed table. Typed rows pin cid/slot/prp2/nlb right after reset
    // with the list base still 0; the rest go through the predictor.
    //      wr    ns             lba                    cnt    addr
    add_row(1'b0, 32'h0,         64'h0,                 8'd1,   64'h0,
            1, 16'd1, 4'd0, 64'h0,    7'd0);     // smallest read
    add_row(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'd8, 64'h0,
            1, 16'd2, 4'd1, 64'h0,    7'd7);     // exactly one page
    add_row(1'b0, 32'h1,         64'h1,                 8'd9,   64'h0,
            1, 16'd3, 4'd2, 64'h1000, 7'd8);     // spills into page two
    add_row(1'b1, 32'h2,         64'h2,                 8'd0,   64'h1000,
            1, 16'd4, 4'd3, 64'h0,    7'd0);     // zero count = one sector
    add_row(1'b0, 32'h3,         64'h3,                 8'd255, 64'h0,
            1, 16'd5, 4'd4, 64'h0,    7'd127);   // saturated, list of 15
    add_row(1'b1, 32'h4,         64'h4,                 8'd128, 64'h0,
            1, 16'd6, 4'd5, 64'h0,    7'd127);   // largest legal count
    add_row(1'b0, 32'h5,         64'h5,                 8'd129, 64'h2000,
            1, 16'd7, 4'd6, 64'h0,    7'd127);   // just over the limit
    add_row(1'b1, 32'h6,         64'h6,                 8'd16,  64'h0,
            1, 16'd8, 4'd7, 64'h1000, 7'd15);    // two full pages
    add_row(1'b0, 32'h7,         64'h7,                 8'd17,  64'h0,
            1, 16'd9, 4'd8, 64'h0,    7'd16);    // smallest list
    add_row(1'b1, 32'h8, 64'h8, 8'd128, 64'h0000_0000_1234_5FFC,
            0, '0, '0, '0, '0);                  // full 16-entry list
    add_row(1'b0, 32'h9, 64'h9, 8'd128, 64'hFFFF_FFFF_FFFF_FFFC,
            0, '0, '0, '0, '0);                  // list pages wrap past 2^64
    add_row(1'b1, 32'hA, 64'hA, 8'd9,   64'hFFFF_FFFF_FFFF_E000,
            0, '0, '0, '0, '0);                  // second page at the top
    add_row(1'b0, 32'hB, 64'hB, 8'd1,   64'h0000_0000_0000_0FFF,
            0, '0, '0, '0, '0);                  // unaligned, one byte left
    add_row(1'b1, 32'hC, 64'hC, 8'd8,   64'h0000_0000_0000_0203,
            0, '0, '0, '0, '0);                  // unaligned mid page
    add_row(1'b0, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 8'd64,
            64'hAAAA_AAAA_AAAA_AAA8, 0, '0, '0, '0, '0);
    add_row(1'b1, 32'h5555_5555, 64'h5555_5555_5555_5555, 8'd127,
            64'h5555_5555_5555_5554, 0, '0, '0, '0, '0);
    add_row(1'b0, 32'hD, 64'hD, 8'd2,   64'h0000_0000_0000_0FFC,
            0, '0, '0, '0, '0);                  // queue slot wraps to 0
    add_row(1'b1, 32'hE, 64'hE, 8'd200, 64'h8000_0000_0000_0000,
            0, '0, '0, '0, '0);
    add_row(1'b0, 32'hF, 64'hF, 8'd33,  64'h7FFF_FFFF_FFFF_F004,
            0, '0, '0, '0, '0);

    foreach (request_rows[k]) issue(request_rows[k]);
    drain();

    // list base at all ones, normal idling on both sides
    set_list_base('1);
    random_phase(25);
    drain();

    // random list base, receiver holds off while requests keep coming
    set_list_base({$urandom, $urandom});
    hold_req = 1'b1;
    random_phase(25);
    drain();

    // list base back to zero, back-to-back items with no idling, then normal idling
    set_list_base('0);
    no_idle = 1'b1;
    random_phase(15);
    no_idle = 1'b0;
    random_phase(15);
    drain();

    // a few short requests at full rate
    set_list_base({$urandom, $urandom});
    no_idle = 1'b1;
    for (k = 0; k < 6; k++) issue(random_request(1'b1));
    no_idle = 1'b0;
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests: %0d PRP list items and %0d commands checked.",
             requests_sent, list_items_seen, commands_seen);
    $display("List base at 0, all ones and random values; one long receiver hold-off.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/nvcb_pkg.sv
rtl/core/nvcb_ctrl.sv
rtl/core/nvcb_dp.sv
rtl/core/nvme_io_command_builder.sv
rtl/core/nvcb_chk.sv
dv/testbench.sv
